// ----- rtl/lprip_pkg.sv -----
// ---------------------------------------------------------------------------
// Lidar range image projection package
// Shared widths, register codes, reset values and the arctangent table.
// ---------------------------------------------------------------------------
package lprip_pkg;

   localparam int COORD_W  = 24;
   localparam int INTEN_W  = 16;
   localparam int RING_W   = 8;
   localparam int COL_W    = 12;

   localparam int RANGE_W  = 23;
   localparam int RCOUNT_W = 9;
   localparam int RATE_W   = 5;
   localparam int CCOUNT_W = 13;

   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;

   localparam int MAX_COLUMNS       = 4096;
   localparam int CORDIC_STAGES_DEF = 20;
   localparam int TAB_LEN           = 32;

   // datapath widths
   localparam int FRAC_SH  = 30;
   localparam int CORDIC_W = 58;
   localparam int ANGLE_W  = 34;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int LIM_W    = 2 * RANGE_W;
   localparam int OFF_W    = ANGLE_W + 1;
   localparam int PROD_W   = OFF_W + CCOUNT_W + 1;
   localparam int Q_W      = PROD_W - 32;
   localparam int CSUM_W   = Q_W + 2;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(64'sd2147483648);
   localparam logic signed [OFF_W-1:0]   QUARTER_TURN = OFF_W'(64'sd1073741824);

   localparam logic [RANGE_W-1:0]  MIN_RANGE_RST  = RANGE_W'(1000);
   localparam logic [RANGE_W-1:0]  MAX_RANGE_RST  = RANGE_W'(100000);
   localparam logic [RCOUNT_W-1:0] RING_COUNT_RST = RCOUNT_W'(32);
   localparam logic [RATE_W-1:0]   RATE_RST       = RATE_W'(1);
   localparam logic [CCOUNT_W-1:0] COL_COUNT_RST  = CCOUNT_W'(1800);
   localparam logic [CCOUNT_W-1:0] COL_LIMIT      = CCOUNT_W'(MAX_COLUMNS);

   typedef enum logic [2:0] {
      REG_MIN_RANGE  = 3'd0,
      REG_MAX_RANGE  = 3'd1,
      REG_RING_COUNT = 3'd2,
      REG_RATE       = 3'd3,
      REG_COL_COUNT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [INTEN_W-1:0]        inten;
      logic [RING_W-1:0]         ring;
   } point_type;

   // atan(2^-i) in Q32 turns
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] v;
      begin
         unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
         endcase
         return v;
      end
   endfunction

endpackage

// ----- rtl/lprip_if.sv -----
// ---------------------------------------------------------------------------
// Lidar range image projection channels
// Point channel and projected point channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lprip_req_if import lprip_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic [INTEN_W-1:0]        point_intensity;
   logic [RING_W-1:0]         ring_number;

   modport source (output valid, point_x, point_y, point_z, point_intensity, ring_number,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, point_intensity, ring_number,
                 output ready);
endinterface

interface lprip_rsp_if import lprip_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic signed [COORD_W-1:0] out_z;
   logic [INTEN_W-1:0]        out_intensity;
   logic [RING_W-1:0]         out_ring;
   logic [COL_W-1:0]          out_column;

   modport source (output valid, out_x, out_y, out_z, out_intensity, out_ring, out_column,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, out_intensity, out_ring, out_column,
                 output ready);
endinterface

// ----- rtl/lprip_cordic.sv -----
// ---------------------------------------------------------------------------
// Lidar range image projection azimuth pipeline
// Vectoring CORDIC, one rotation per stage, with the ring downsample
// remainder worked out one bit per stage alongside.
// ---------------------------------------------------------------------------
module lprip_cordic import lprip_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  point_type                 in_pt,
   input  logic [RATE_W-1:0]         rate,
   output logic                      out_valid,
   input  logic                      out_ready,
   output point_type                 out_pt,
   output logic signed [ANGLE_W-1:0] out_angle,
   output logic                      out_div_ok
);

   typedef struct packed {
      logic signed [CORDIC_W-1:0] cx;
      logic signed [CORDIC_W-1:0] cy;
      logic signed [ANGLE_W-1:0]  ang;
      logic                       zero;
      logic [RATE_W-1:0]          rem;
      point_type                  pt;
   } cordic_type;

   cordic_type st_ff  [0:STAGES];
   logic       vld_ff [0:STAGES];
   logic       rdy    [0:STAGES];

   logic [RATE_W-1:0]          rate_eff;
   logic signed [CORDIC_W-1:0] cx_pre;
   logic signed [CORDIC_W-1:0] cy_pre;
   cordic_type                 pre_in;

   assign rate_eff = (rate == '0) ? RATE_W'(1) : rate;

   assign cx_pre = {{(CORDIC_W-COORD_W-FRAC_SH){in_pt.y[COORD_W-1]}}, in_pt.y,
                    {FRAC_SH{1'b0}}};
   assign cy_pre = {{(CORDIC_W-COORD_W-FRAC_SH){in_pt.x[COORD_W-1]}}, in_pt.x,
                    {FRAC_SH{1'b0}}};

   // pre-rotate into the right half plane
   always_comb begin
      pre_in.pt   = in_pt;
      pre_in.rem  = '0;
      pre_in.zero = (in_pt.x == '0) && (in_pt.y == '0);
      if (cx_pre < 0) begin
         pre_in.cx  = -cx_pre;
         pre_in.cy  = -cy_pre;
         pre_in.ang = in_pt.x[COORD_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         pre_in.cx  = cx_pre;
         pre_in.cy  = cy_pre;
         pre_in.ang = '0;
      end
   end

   assign in_ready = rdy[0];
   assign rdy[0] = !vld_ff[0] || rdy[1];
   assign rdy[STAGES] = !vld_ff[STAGES] || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         st_ff[0] <= pre_in;
      end
   end

   for (genvar k = 1; k <= STAGES; k++) begin : g_stage
      localparam int I = k - 1;
      cordic_type             nxt_in;
      logic [RATE_W:0]        rem_sh;
      logic signed [ANGLE_W-1:0] tab;

      assign tab = $signed({{(ANGLE_W-32){1'b0}}, atan_turn(I)});

      if (k < STAGES) begin : g_rdy
         assign rdy[k] = !vld_ff[k] || rdy[k+1];
      end

      if (I < RING_W) begin : g_div
         assign rem_sh = {st_ff[k-1].rem, st_ff[k-1].pt.ring[RING_W-1-I]};
      end else begin : g_nodiv
         assign rem_sh = {1'b0, st_ff[k-1].rem};
      end

      always_comb begin
         nxt_in = st_ff[k-1];
         if (st_ff[k-1].cy >= 0) begin
            nxt_in.cx  = st_ff[k-1].cx + (st_ff[k-1].cy >>> I);
            nxt_in.cy  = st_ff[k-1].cy - (st_ff[k-1].cx >>> I);
            nxt_in.ang = st_ff[k-1].ang + tab;
         end else begin
            nxt_in.cx  = st_ff[k-1].cx - (st_ff[k-1].cy >>> I);
            nxt_in.cy  = st_ff[k-1].cy + (st_ff[k-1].cx >>> I);
            nxt_in.ang = st_ff[k-1].ang - tab;
         end
         if (rem_sh >= {1'b0, rate_eff}) begin
            nxt_in.rem = RATE_W'(rem_sh - {1'b0, rate_eff});
         end else begin
            nxt_in.rem = rem_sh[RATE_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && vld_ff[k-1]) begin
            st_ff[k] <= nxt_in;
         end
      end
   end

   assign out_valid  = vld_ff[STAGES];
   assign out_pt     = st_ff[STAGES].pt;
   assign out_angle  = st_ff[STAGES].zero ? '0 : st_ff[STAGES].ang;
   assign out_div_ok = (st_ff[STAGES].rem == '0);

endmodule

// ----- rtl/lidar_point_range_image_projection.sv -----
// Throughput: one point per cycle unless the result channel stalls; each pipeline
// stage holds one point and every CORDIC rotation has a stage of its own. Dropped
// points leave no result.
// Reset: synchronous, clears all valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
// Lidar point range image projection
// Range and ring filtering, CORDIC azimuth and column computation.
// ---------------------------------------------------------------------------
module lidar_point_range_image_projection import lprip_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   lprip_req_if.sink          req,
   lprip_rsp_if.source        rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   // ---------------- registers ----------------
   logic [RANGE_W-1:0]  min_range_ff;
   logic [RANGE_W-1:0]  max_range_ff;
   logic [RCOUNT_W-1:0] ring_count_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [CCOUNT_W-1:0] col_count_ff;
   csr_index_type       csr_idx;
   logic [CCOUNT_W-1:0] h_sat;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[PADDR_W-1:2]);
   assign h_sat   = (col_count_ff > COL_LIMIT) ? COL_LIMIT : col_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff  <= MIN_RANGE_RST;
         max_range_ff  <= MAX_RANGE_RST;
         ring_count_ff <= RING_COUNT_RST;
         rate_ff       <= RATE_RST;
         col_count_ff  <= COL_COUNT_RST;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx)
            REG_MIN_RANGE:  min_range_ff  <= pwdata[RANGE_W-1:0];
            REG_MAX_RANGE:  max_range_ff  <= pwdata[RANGE_W-1:0];
            REG_RING_COUNT: ring_count_ff <= pwdata[RCOUNT_W-1:0];
            REG_RATE:       rate_ff       <= pwdata[RATE_W-1:0];
            REG_COL_COUNT:  col_count_ff  <= pwdata[CCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIN_RANGE:  prdata = PDATA_W'(min_range_ff);
         REG_MAX_RANGE:  prdata = PDATA_W'(max_range_ff);
         REG_RING_COUNT: prdata = PDATA_W'(ring_count_ff);
         REG_RATE:       prdata = PDATA_W'(rate_ff);
         REG_COL_COUNT:  prdata = PDATA_W'(col_count_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- stage A: input register ----------------
   logic      a_vld_ff, a_rdy;
   point_type a_pt_ff;
   logic      b_vld_ff, b_rdy;
   logic      c_vld_ff, c_rdy;
   logic      d_vld_ff, d_rdy;

   assign a_rdy     = !a_vld_ff || b_rdy;
   assign req.ready = a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_rdy) begin
         a_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && req.valid) begin
         a_pt_ff.x     <= req.point_x;
         a_pt_ff.y     <= req.point_y;
         a_pt_ff.z     <= req.point_z;
         a_pt_ff.inten <= req.point_intensity;
         a_pt_ff.ring  <= req.ring_number;
      end
   end

   // ---------------- stage B: squares ----------------
   point_type              b_pt_ff;
   logic [SQ_W-1:0]        b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic [LIM_W-1:0]       b_min2_ff, b_max2_ff;
   logic                   b_ok_ff;
   logic signed [SQ_W-1:0] sqx_in, sqy_in, sqz_in;
   logic                   b_ok_in;

   assign sqx_in  = a_pt_ff.x * a_pt_ff.x;
   assign sqy_in  = a_pt_ff.y * a_pt_ff.y;
   assign sqz_in  = a_pt_ff.z * a_pt_ff.z;
   assign b_ok_in = ({1'b0, a_pt_ff.ring} < ring_count_ff) && (h_sat != '0);
   assign b_rdy   = !b_vld_ff || c_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_rdy) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_rdy && a_vld_ff) begin
         b_pt_ff   <= a_pt_ff;
         b_sqx_ff  <= $unsigned(sqx_in);
         b_sqy_ff  <= $unsigned(sqy_in);
         b_sqz_ff  <= $unsigned(sqz_in);
         b_min2_ff <= min_range_ff * min_range_ff;
         b_max2_ff <= max_range_ff * max_range_ff;
         b_ok_ff   <= b_ok_in;
      end
   end

   // ---------------- stage C: squared range ----------------
   point_type        c_pt_ff;
   logic [SQ_W-1:0]  c_r2_ff;
   logic [LIM_W-1:0] c_min2_ff, c_max2_ff;
   logic             c_ok_ff;

   assign c_rdy = !c_vld_ff || d_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (c_rdy) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_rdy && b_vld_ff) begin
         c_pt_ff   <= b_pt_ff;
         c_r2_ff   <= b_sqx_ff + b_sqy_ff + b_sqz_ff;
         c_min2_ff <= b_min2_ff;
         c_max2_ff <= b_max2_ff;
         c_ok_ff   <= b_ok_ff;
      end
   end

   // ---------------- stage D: range gate ----------------
   point_type d_pt_ff;
   logic      d_keep_in;
   logic      cor_in_rdy;

   assign d_keep_in = c_ok_ff && (c_r2_ff >= SQ_W'(c_min2_ff)) && (c_r2_ff <= SQ_W'(c_max2_ff));
   assign d_rdy     = !d_vld_ff || cor_in_rdy;

   // drop out-of-range and out-of-ring points here
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (d_rdy) begin
         d_vld_ff <= c_vld_ff && d_keep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_rdy && c_vld_ff) begin
         d_pt_ff <= c_pt_ff;
      end
   end

   // ---------------- azimuth ----------------
   logic                      cor_vld, cor_div_ok, e_rdy;
   point_type                 cor_pt;
   logic signed [ANGLE_W-1:0] cor_ang;

   lprip_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_vld_ff),
      .in_ready   (cor_in_rdy),
      .in_pt      (d_pt_ff),
      .rate       (rate_ff),
      .out_valid  (cor_vld),
      .out_ready  (e_rdy),
      .out_pt     (cor_pt),
      .out_angle  (cor_ang),
      .out_div_ok (cor_div_ok)
   );

   // ---------------- stage E: column product ----------------
   logic                     e_vld_ff, f_rdy;
   point_type                e_pt_ff;
   logic signed [PROD_W-1:0] e_s_ff;
   logic signed [OFF_W-1:0]  ang_off;
   logic signed [PROD_W-1:0] s_in;

   assign ang_off = {cor_ang[ANGLE_W-1], cor_ang} - QUARTER_TURN;
   assign s_in    = ang_off * $signed({1'b0, h_sat});
   assign e_rdy   = !e_vld_ff || f_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (e_rdy) begin
         e_vld_ff <= cor_vld && cor_div_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (e_rdy && cor_vld) begin
         e_pt_ff <= cor_pt;
         e_s_ff  <= s_in;
      end
   end

   // ---------------- stage F: round half away from zero ----------------
   logic              f_vld_ff, g_rdy;
   point_type         f_pt_ff;
   logic [Q_W-1:0]    f_q_ff;
   logic              f_neg_ff;
   logic [PROD_W-1:0] mag_in, rnd_in;

   assign mag_in = e_s_ff[PROD_W-1] ? $unsigned(-e_s_ff) : $unsigned(e_s_ff);
   assign rnd_in = mag_in + (PROD_W'(1) << 31);
   assign f_rdy  = !f_vld_ff || g_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (f_rdy) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_rdy && e_vld_ff) begin
         f_pt_ff  <= e_pt_ff;
         f_q_ff   <= rnd_in[PROD_W-1:32];
         f_neg_ff <= e_s_ff[PROD_W-1];
      end
   end

   // ---------------- stage G: column, output register ----------------
   logic                     g_vld_ff;
   point_type                g_pt_ff;
   logic [COL_W-1:0]         g_col_ff;
   logic signed [CSUM_W-1:0] half_h, q_s, h_s, col_in, colw_in;
   logic                     g_keep_in;

   assign half_h = $signed({{(CSUM_W-CCOUNT_W+1){1'b0}}, h_sat[CCOUNT_W-1:1]});
   assign h_s    = $signed({{(CSUM_W-CCOUNT_W){1'b0}}, h_sat});
   assign q_s    = $signed({2'b00, f_q_ff});
   assign col_in = f_neg_ff ? (half_h + q_s) : (half_h - q_s);
   // wrap once past the last column
   assign colw_in   = (col_in >= h_s) ? (col_in - h_s) : col_in;
   assign g_keep_in = !colw_in[CSUM_W-1] && (colw_in < h_s);
   assign g_rdy     = !g_vld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (g_rdy) begin
         g_vld_ff <= f_vld_ff && g_keep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (g_rdy && f_vld_ff) begin
         g_pt_ff  <= f_pt_ff;
         g_col_ff <= colw_in[COL_W-1:0];
      end
   end

   assign rsp.valid         = g_vld_ff;
   assign rsp.out_x         = g_pt_ff.x;
   assign rsp.out_y         = g_pt_ff.y;
   assign rsp.out_z         = g_pt_ff.z;
   assign rsp.out_intensity = g_pt_ff.inten;
   assign rsp.out_ring      = g_pt_ff.ring;
   assign rsp.out_column    = g_col_ff;

endmodule

// ----- rtl/lprip_checker.sv -----
// ---------------------------------------------------------------------------
// Lidar range image projection port checker
// Watches the result channel and the register port over time.
// ---------------------------------------------------------------------------
module lprip_checker import lprip_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] rsp_out_x,
   input logic [COL_W-1:0]          rsp_out_column,
   input logic                      psel,
   input logic                      penable,
   input logic                      pwrite,
   input logic [PADDR_W-1:0]        paddr,
   input logic [PDATA_W-1:0]        pwdata,
   input logic [PDATA_W-1:0]        prdata
);

   localparam logic [PADDR_W-1:0] RING_ADDR = PADDR_W'(4 * REG_RING_COUNT);

   // nothing leaves the pipeline in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // a stalled transaction keeps its payload
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_column))
      else $error("stalled result changed");

   // a ring count write reads back on a read that directly follows it
   a_ring_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr == RING_ADDR) ##1
      (psel && !pwrite && paddr == RING_ADDR)
      |-> prdata == PDATA_W'($past(pwdata[RCOUNT_W-1:0])))
      else $error("ring count read back wrong");

endmodule

bind lidar_point_range_image_projection lprip_checker u_lprip_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_x      (rsp.out_x),
   .rsp_out_column (rsp.out_column),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata)
);

// ----- dv/tb_lidar_point_range_image_projection.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range image projection testbench
// Drives points through the projection block under several register
// settings and idle patterns, and checks each kept point against a local
// CORDIC and column predictor.
// ---------------------------------------------------------------------------
module tb_lidar_point_range_image_projection;
   import lprip_pkg::*;

   localparam int LATENCY   = CORDIC_STAGES_DEF + 8;
   localparam int WD_LIMIT  = 20000;
   localparam int N_RANDOM  = 1820;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [INTEN_W-1:0]        inten;
      logic [RING_W-1:0]         ring;
      logic [COL_W-1:0]          col;
   } proj_point_type;

   typedef struct {
      point_type pt;
      bit        kept;
      int        col;   // -2: use predictor
   } dir_row_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   lprip_req_if req_if ();
   lprip_rsp_if rsp_if ();

   lidar_point_range_image_projection i_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // register shadow
   logic [RANGE_W-1:0]  min_rng;
   logic [RANGE_W-1:0]  max_rng;
   logic [RCOUNT_W-1:0] ring_cnt;
   logic [RATE_W-1:0]   ds_rate;
   logic [CCOUNT_W-1:0] col_cnt;

   longint unsigned turn_tab[TAB_LEN];
   proj_point_type  expected_points[$];
   int  n_errors, n_mismatch, n_points_in, n_points_out, n_dropped;
   int  idle_in_pct, stall_pct;
   bit  hold_off, stim_done;
   int  wd_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // arctangent of 2^-i in Q32 turns, built from its power series
   function automatic void build_turn_table();
      longint acc, term;
      longint unsigned rad32, t;
      int k, p;
      turn_tab[0] = 64'd536870912;
      for (int i = 1; i < TAB_LEN; i++) begin
         acc = 0;
         k = 0;
         while ((2 * k + 1) * i <= 60) begin
            p = 2 * k + 1;
            term = longint'((64'd1 << (60 - p * i)) / p);
            acc = (k % 2) ? acc - term : acc + term;
            k++;
         end
         rad32 = (longint'(acc) + (64'd1 << 27)) >> 28;
         t = (rad32 * 64'hA2F9836E + (64'd1 << 33)) >> 34;
         turn_tab[i] = t & 64'hFFFF_FFFF;
      end
   endfunction

   function automatic longint azimuth_turns(longint num, longint den);
      longint cx, cy, nx, ny, z;
      z = 0;
      if (num == 0 && den == 0) return 0;
      cx = den <<< 30;
      cy = num <<< 30;
      if (cx < 0) begin
         z = (num >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         cx = -cx;
         cy = -cy;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            z += longint'(turn_tab[i]);
         end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            z -= longint'(turn_tab[i]);
         end
         cx = nx;
         cy = ny;
      end
      return z;
   endfunction

   // column of a point, or -1 when the point is dropped
   function automatic int project_column(point_type pt);
      longint x, y, z, s, col, h;
      longint unsigned r2, mag, q, rate;
      x = pt.x; y = pt.y; z = pt.z;
      r2 = longint'(x * x) + longint'(y * y) + longint'(z * z);
      if (r2 < longint'(min_rng) * min_rng || r2 > longint'(max_rng) * max_rng) return -1;
      if (pt.ring >= ring_cnt) return -1;
      rate = (ds_rate == 0) ? 1 : ds_rate;
      if (pt.ring % rate != 0) return -1;
      h = (col_cnt > MAX_COLUMNS) ? MAX_COLUMNS : col_cnt;
      if (h == 0) return -1;
      s = (azimuth_turns(x, y) - 64'sd1073741824) * h;
      mag = (s < 0) ? -s : s;
      q = (mag + (64'd1 << 31)) >> 32;
      col = h / 2;
      col = (s < 0) ? col + longint'(q) : col - longint'(q);
      if (col >= h) col -= h;
      if (col < 0 || col >= h) return -1;
      return int'(col);
   endfunction

   function automatic proj_point_type make_proj(point_type pt, int col);
      proj_point_type r;
      r.x = pt.x; r.y = pt.y; r.z = pt.z;
      r.inten = pt.inten; r.ring = pt.ring; r.col = col[COL_W-1:0];
      return r;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [PDATA_W-1:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= PADDR_W'(idx) << 2; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_MIN_RANGE:  min_rng  = val[RANGE_W-1:0];
         REG_MAX_RANGE:  max_rng  = val[RANGE_W-1:0];
         REG_RING_COUNT: ring_cnt = val[RCOUNT_W-1:0];
         REG_RATE:       ds_rate  = val[RATE_W-1:0];
         REG_COL_COUNT:  col_cnt  = val[CCOUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int mn, int mx, int rc, int ds, int cc);
      write_csr(REG_MIN_RANGE, mn);
      write_csr(REG_MAX_RANGE, mx);
      write_csr(REG_RING_COUNT, rc);
      write_csr(REG_RATE, ds);
      write_csr(REG_COL_COUNT, cc);
   endtask

   // offer one point and hold it until the transaction; queue its projection
   task automatic send_point(point_type pt, int want_col);
      int col;
      while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      col = project_column(pt);
      if (want_col != -2 && want_col != col) begin
         n_errors++;
         $display("directed row: predicted column %0d, table says %0d", col, want_col);
      end
      if (col >= 0) expected_points = {expected_points, make_proj(pt, col)};
      else n_dropped++;
      req_if.valid <= 1'b1;
      req_if.point_x <= pt.x; req_if.point_y <= pt.y; req_if.point_z <= pt.z;
      req_if.point_intensity <= pt.inten; req_if.ring_number <= pt.ring;
      do @(posedge clock); while (!req_if.ready);
      n_points_in++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_points.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic point_type rand_point(bit well_formed);
      point_type pt;
      int sh;
      sh = $urandom_range(23);
      pt.x = COORD_W'($signed($urandom()) >>> (8 + sh));
      pt.y = COORD_W'($signed($urandom()) >>> (8 + $urandom_range(23)));
      pt.z = COORD_W'($signed($urandom()) >>> (8 + $urandom_range(23)));
      if (!well_formed && $urandom_range(3) == 0) begin
         pt.x = COORD_W'($urandom()); pt.y = COORD_W'($urandom());
         pt.z = COORD_W'($urandom());
      end
      pt.inten = INTEN_W'($urandom());
      pt.ring = well_formed ? RING_W'($urandom_range(63)) : RING_W'($urandom());
      if (well_formed && ds_rate > 1) pt.ring = pt.ring - (pt.ring % ds_rate);
      return pt;
   endfunction

   // result side: random stall, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !hold_off && !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      proj_point_type exp_pt, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_points_out++;
         got.x = rsp_if.out_x; got.y = rsp_if.out_y; got.z = rsp_if.out_z;
         got.inten = rsp_if.out_intensity; got.ring = rsp_if.out_ring;
         got.col = rsp_if.out_column;
         if (expected_points.size() == 0) begin
            n_errors++;
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected point: %p", got);
         end else begin
            exp_pt = expected_points.pop_front();
            if (got !== exp_pt) begin
               n_errors++;
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("point mismatch: expected %p, got %p", exp_pt, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
         wd_count <= 0;
      else if (!stim_done || expected_points.size() > 0) begin
         wd_count <= wd_count + 1;
         if (wd_count >= WD_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      point_type pt;
      int ph_idle[4];
      int ph_stall[4];
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_if.valid = 1'b0; req_if.point_x = '0; req_if.point_y = '0;
      req_if.point_z = '0; req_if.point_intensity = '0; req_if.ring_number = '0;
      hold_off = 1'b0; stim_done = 1'b0; wd_count = 0;
      idle_in_pct = 0; stall_pct = 0;
      n_errors = 0; n_mismatch = 0; n_points_in = 0; n_points_out = 0; n_dropped = 0;
      min_rng = MIN_RANGE_RST; max_rng = MAX_RANGE_RST; ring_cnt = RING_COUNT_RST;
      ds_rate = RATE_RST; col_cnt = COL_COUNT_RST;
      build_turn_table();
      ph_idle  = '{0, 48, 0, 35};
      ph_stall = '{0, 0, 48, 35};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, H = 1800
      dir_rows = '{
         '{'{24'sd5000, 24'sd0, 24'sd0, 16'hFFFF, 8'd0}, 1, 900},    // +x axis
         '{'{24'sd0, 24'sd5000, 24'sd0, 16'h0000, 8'd31}, 1, 1350},  // +y axis
         '{'{-24'sd5000, 24'sd0, 24'sd0, 16'h1234, 8'd1}, 1, 0},     // -x axis
         '{'{24'sd0, -24'sd5000, 24'sd0, 16'h8000, 8'd2}, 1, 450},   // -y axis
         '{'{24'sd0, 24'sd0, 24'sd999, 16'h0001, 8'd0}, 0, -1},      // below minimum
         '{'{24'sd0, 24'sd0, 24'sd1000, 16'h0002, 8'd0}, 1, 1350},   // zero vector
         '{'{24'sd0, 24'sd0, 24'sd100000, 16'h0003, 8'd0}, 1, 1350},
         '{'{24'sd0, 24'sd0, 24'sd100001, 16'h0004, 8'd0}, 0, -1},   // above maximum
         '{'{24'sd3000, 24'sd0, 24'sd0, 16'h0005, 8'd32}, 0, -1},    // ring too high
         '{'{24'sd3000, 24'sd0, 24'sd0, 16'h0006, 8'd255}, 0, -1},
         '{'{24'sd3000, 24'sd3000, 24'sd0, 16'h0007, 8'd5}, 1, -2},
         '{'{-24'sd3000, -24'sd3000, 24'sd0, 16'h0008, 8'd6}, 1, -2},
         '{'{24'sd2000, -24'sd7000, -24'sd400, 16'h0009, 8'd7}, 1, -2}
      };
      foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].kept ? dir_rows[i].col : -1);
      drain();

      // extremes: whole range window, all rings, widest image
      set_config(0, 8388607, 256, 1, 4096);
      send_point('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 8'd255}, -2);
      send_point('{24'sh800000, 24'sh800000, 24'sh800000, 16'h0000, 8'd0}, -2);
      send_point('{24'sh800000, 24'sd0, 24'sd0, 16'h5A5A, 8'd128}, -2);
      send_point('{24'sd0, 24'sd0, 24'sd0, 16'hA5A5, 8'd64}, -2);
      drain();
      // special settings: rate zero, ring count zero, column count zero, min above max
      set_config(0, 8388607, 256, 0, 5000);
      send_point('{24'sd100, -24'sd200, 24'sd5, 16'h1111, 8'd3}, -2);
      drain();
      write_csr(REG_RING_COUNT, 0);
      send_point('{24'sd100, 24'sd200, 24'sd5, 16'h2222, 8'd0}, -1);
      drain();
      write_csr(REG_RING_COUNT, 256);
      write_csr(REG_COL_COUNT, 0);
      send_point('{24'sd100, 24'sd200, 24'sd5, 16'h3333, 8'd0}, -1);
      drain();
      write_csr(REG_COL_COUNT, 1);
      write_csr(REG_MIN_RANGE, 500);
      write_csr(REG_MAX_RANGE, 400);
      send_point('{24'sd450, 24'sd0, 24'sd0, 16'h4444, 8'd0}, -1);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: set_config(1000, 100000, 32, 1, 1800);
            1: set_config($urandom_range(2000), 8388607, 256, $urandom_range(1, 16), 4096);
            2: set_config(0, $urandom_range(1000, 8388607), $urandom_range(1, 256),
                          $urandom_range(0, 31), $urandom_range(1, 8191));
            default: set_config(10, 3000000, 64, 2, $urandom_range(1, 16));
         endcase
         idle_in_pct = ph_idle[ph % 4];
         stall_pct = ph_stall[ph % 4];
         if (ph == 2) begin
            // hold the result side off long enough to back the pipeline up
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < N_RANDOM / 8; n++) begin
            pt = rand_point($urandom_range(9) < 8);
            send_point(pt, -2);
            if (ph == 5 && n == 100) begin
               req_if.valid <= 1'b0;
               do @(posedge clock); while (expected_points.size() > 0);
            end
         end
         drain();
      end

      stim_done = 1'b1;
      idle_in_pct = 0;
      stall_pct = 0;
      drain();
      $display("Sent %0d points under %0d register settings; %0d projected, %0d dropped.",
               n_points_in, 13, n_points_out, n_dropped);
      if (n_errors == 0 && expected_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
